@@ rtl/ept_pkg.sv @@
// Shared types and constants for the entropy price table.
// No dependencies; compiled first.
`default_nettype none

package ept_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned IN_COUNT_W = 20;
  localparam int unsigned PRICE_W    = 13;
  localparam int unsigned FLOOR_W    = 9;

  // log2 fixed point: fraction bits of the result, fraction bits of the mantissa
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned MANT_FRAC = 31;
  localparam int unsigned MANT_W    = MANT_FRAC + 1;

  localparam logic [PRICE_W-1:0] PRICE_MAX   = '1;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

endpackage

`default_nettype wire

@@ rtl/ept_if.sv @@
// Stream interfaces of the entropy price table: request, response, config write.
// Depends on ept_pkg.
`default_nettype none

interface ept_req_if import ept_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_e                  op;
  logic [INDEX_W-1:0]   index;
  logic [IN_COUNT_W-1:0] count;

  modport source (output valid, op, index, count, input ready);
  modport sink   (input valid, op, index, count, output ready);
endinterface

interface ept_rsp_if import ept_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic               known;

  modport source (output valid, price, known, input ready);
  modport sink   (input valid, price, known, output ready);
endinterface

interface ept_cfg_if import ept_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/ept_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ept_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ept_log2.sv @@
// Iterative fixed-point log2: leading-zero search one shift step per cycle,
// then one mantissa squaring per cycle for each fraction bit. Depends on ept_pkg.
`default_nettype none

module ept_log2 import ept_pkg::*; #(
  parameter int unsigned XW = 28
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [XW-1:0] x_i,
  output      logic          busy_o,
  output      logic [$clog2((XW <= MANT_W) ? MANT_W : 2 * MANT_W) + FRAC_BITS - 1:0] res_o
);

  localparam int unsigned NW     = (XW <= MANT_W) ? MANT_W : 2 * MANT_W;
  localparam int unsigned NSTEPS = $clog2(NW);
  localparam int unsigned RW     = NSTEPS + FRAC_BITS;

  typedef enum logic [2:0] {
    LG_IDLE = 3'b001,
    LG_NORM = 3'b010,
    LG_SQR  = 3'b100
  } lg_state_e;

  lg_state_e             state_q, state_d;
  logic [NW-1:0]         norm_q, norm_d;
  logic [NSTEPS-1:0]     lz_q, lz_d;
  logic [NSTEPS-1:0]     sh_q, sh_d;     // current shift amount, one-hot
  logic [MANT_W-1:0]     m_q, m_d;
  logic [FRAC_BITS-1:0]  fbit_q, fbit_d; // fraction bit found this round
  logic [RW-1:0]         res_q, res_d;

  logic [2*MANT_W-1:0]   prod;
  logic [MANT_W:0]       sq;
  logic                  top_zero;
  logic [NSTEPS-1:0]     hb;

  assign prod     = {{MANT_W{1'b0}}, m_q} * {{MANT_W{1'b0}}, m_q};
  assign sq       = prod[MANT_FRAC +: MANT_W + 1];
  assign top_zero = (norm_q >> (NW - int'(sh_q))) == '0;
  assign hb       = NSTEPS'(NW - 1) - lz_q;

  always_comb begin
    state_d = state_q;
    norm_d  = norm_q;
    lz_d    = lz_q;
    sh_d    = sh_q;
    m_d     = m_q;
    fbit_d  = fbit_q;
    res_d   = res_q;
    case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          norm_d  = (x_i == '0) ? NW'(1) : NW'(x_i);
          lz_d    = '0;
          sh_d    = NSTEPS'(NW / 2);
          state_d = LG_NORM;
        end
      end
      LG_NORM: begin
        if (top_zero) begin
          norm_d = norm_q << int'(sh_q);
          lz_d   = lz_q + sh_q;
        end
        sh_d = sh_q >> 1;
        if (sh_q == NSTEPS'(1)) begin
          m_d     = norm_d[NW-1 -: MANT_W];
          res_d   = {((top_zero) ? hb - NSTEPS'(1) : hb), {FRAC_BITS{1'b0}}};
          fbit_d  = {1'b1, {(FRAC_BITS-1){1'b0}}};
          state_d = LG_SQR;
        end
      end
      LG_SQR: begin
        if (sq[MANT_W]) begin
          m_d   = sq[MANT_W:1];
          res_d = res_q | RW'(fbit_q);
        end else begin
          m_d = sq[MANT_W-1:0];
        end
        fbit_d = fbit_q >> 1;
        if (fbit_q[0]) begin
          state_d = LG_IDLE;
        end
      end
      default: state_d = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
    lz_q   <= lz_d;
    sh_q   <= sh_d;
    m_q    <= m_d;
    fbit_q <= fbit_d;
    res_q  <= res_d;
  end

  assign busy_o = (state_q != LG_IDLE);
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ rtl/entropy_price_table.sv @@
// Top level of the entropy price table: count memory, valid marks, running total,
// two log2 units and the price output register. Depends on ept_pkg, ept_if,
// ept_ram, ept_log2.
//
//   channel  role      beat                       handshake
//   req_i    sink      op, index, count           valid / ready
//   rsp_o    source    price, known (reads only)  valid / ready
//   cfg_i    sink      floor                      valid / ready, always ready
//
// One item at a time. A load is accepted and then does one read-modify-write on
// the count RAM in ST_MOD; clear, unused op and out-of-range load finish on
// acceptance. A read starts both log2 units in ST_MOD and waits in ST_LOG for the
// leading-zero search and eight squaring rounds of each before the price is
// registered. Valid marks are flip-flops cleared at once by reset and by clear,
// so no clearing pass. A new item is taken while a response still waits; a read
// then holds in its last step.
`default_nettype none

module entropy_price_table import ept_pkg::*; #(
  parameter int unsigned ENTRIES    = 256,
  parameter int unsigned COUNT_BITS = 20
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  ept_req_if.sink    req_i,
  ept_rsp_if.source  rsp_o,
  ept_cfg_if.sink    cfg_i
);

  localparam int unsigned AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned TW  = COUNT_BITS + $clog2(ENTRIES);
  localparam int unsigned NWT = (TW <= MANT_W) ? MANT_W : 2 * MANT_W;
  localparam int unsigned NWC = (COUNT_BITS <= MANT_W) ? MANT_W : 2 * MANT_W;
  localparam int unsigned LWT = $clog2(NWT) + FRAC_BITS;
  localparam int unsigned LWC = $clog2(NWC) + FRAC_BITS;
  localparam int unsigned DW  = (LWT > PRICE_W) ? LWT : PRICE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOD  = 3'b010,
    ST_LOG  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  op_e                    op_q;
  logic [AW-1:0]          idx_q;
  logic [COUNT_BITS-1:0]  cnt_q;
  logic                   known_q;
  logic [ENTRIES-1:0]     valid_q, valid_d;
  logic [TW-1:0]          total_q, total_d;
  logic [FLOOR_W-1:0]     floor_q;
  logic                   rsp_valid_q, rsp_valid_d;
  logic [PRICE_W-1:0]     rsp_price_q, rsp_price_d;
  logic                   rsp_known_q;

  logic                   req_acc;
  logic                   in_range;
  logic [AW-1:0]          req_idx;
  logic [COUNT_BITS-1:0]  cnt_sat;
  logic                   req_known;
  logic                   ram_we;
  logic                   ram_re;
  logic [COUNT_BITS-1:0]  ram_rdata;
  logic [COUNT_BITS-1:0]  old_cnt;
  logic                   log_start;
  logic                   busy_t, busy_c;
  logic [LWT-1:0]         log_t;
  logic [LWC-1:0]         log_c;
  logic [DW-1:0]          lt_ext, lc_ext, diff, floored;
  logic                   out_free;

  assign req_acc   = req_i.valid && req_i.ready;
  assign in_range  = {1'b0, req_i.index} < (INDEX_W + 1)'(ENTRIES);
  assign req_idx   = AW'(req_i.index);
  assign cnt_sat   = (|(req_i.count >> COUNT_BITS)) ? {COUNT_BITS{1'b1}}
                                                    : COUNT_BITS'(req_i.count);
  assign req_known = in_range && valid_q[req_idx];
  assign ram_re    = req_acc && in_range &&
                     (req_i.op == OP_LOAD || req_i.op == OP_READ);
  assign old_cnt   = known_q ? ram_rdata : '0;
  assign out_free  = !rsp_valid_q || rsp_o.ready;

  ept_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (ENTRIES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (cnt_q),
    .re_i    (ram_re),
    .raddr_i (req_idx),
    .rdata_o (ram_rdata)
  );

  ept_log2 #(.XW(TW)) u_log_total (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (total_q),
    .busy_o  (busy_t),
    .res_o   (log_t)
  );

  ept_log2 #(.XW(COUNT_BITS)) u_log_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (old_cnt),
    .busy_o  (busy_c),
    .res_o   (log_c)
  );

  // price = max(lt - lc, 0), raised to the floor, capped to the field
  assign lt_ext  = DW'(log_t);
  assign lc_ext  = DW'(log_c);
  assign diff    = (lt_ext > lc_ext) ? lt_ext - lc_ext : '0;
  assign floored = (diff < DW'(floor_q)) ? DW'(floor_q) : diff;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    total_d     = total_q;
    ram_we      = 1'b0;
    log_start   = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_price_d = rsp_price_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (req_i.op)
            OP_LOAD: begin
              if (in_range) begin
                state_d = ST_MOD;
              end
            end
            OP_READ:  state_d = ST_MOD;
            OP_CLEAR: begin
              valid_d = '0;
              total_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        if (op_q == OP_LOAD) begin
          ram_we          = 1'b1;
          valid_d[idx_q]  = 1'b1;
          total_d         = total_q - TW'(old_cnt) + TW'(cnt_q);
          state_d         = ST_IDLE;
        end else begin
          log_start = 1'b1;
          state_d   = ST_LOG;
        end
      end
      ST_LOG: begin
        if (!busy_t && !busy_c && out_free) begin
          rsp_valid_d = 1'b1;
          rsp_price_d = (floored > DW'(PRICE_MAX)) ? PRICE_MAX : PRICE_W'(floored);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      total_q     <= '0;
      floor_q     <= FLOOR_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      total_q     <= total_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid) begin
        floor_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q    <= req_i.op;
      idx_q   <= req_idx;
      cnt_q   <= cnt_sat;
      known_q <= req_known;
    end
    if (state_q == ST_LOG && rsp_valid_d && !rsp_valid_q) begin
      rsp_known_q <= known_q;
    end else if (state_q == ST_LOG && rsp_valid_d && rsp_o.ready) begin
      rsp_known_q <= known_q;
    end
    rsp_price_q <= rsp_price_d;
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.price = rsp_price_q;
  assign rsp_o.known = rsp_known_q;

endmodule

`default_nettype wire
